// ===== rtl/tdpt_pkg.sv =====
// shared types and constants of the trial division prime test
package tdpt_pkg;

	localparam int NUM_BITS = 32;
	localparam int CNT_W    = $clog2(NUM_BITS);

	typedef logic signed [NUM_BITS-1:0] num_t;
	typedef logic        [NUM_BITS-1:0] uword_t;
	typedef logic        [CNT_W-1:0]    cnt_t;

	localparam uword_t TWO   = uword_t'(2);
	localparam uword_t THREE = uword_t'(3);

endpackage

// ===== rtl/tdpt_if.sv =====
// valid/ready channel interfaces for query and verdict transactions
interface tdpt_in_if;
	logic             valid;
	logic             ready;
	tdpt_pkg::num_t   number;

	modport source (output valid, output number, input ready);
	modport sink   (input valid, input number, output ready);
endinterface

interface tdpt_out_if;
	logic             valid;
	logic             ready;
	tdpt_pkg::num_t   number_echo;
	logic             is_prime;

	modport source (output valid, output number_echo, output is_prime, input ready);
	modport sink   (input valid, input number_echo, input is_prime, output ready);
endinterface

// ===== rtl/tdpt_div.sv =====
// bit-serial restoring divider giving quotient and remainder
module tdpt_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  tdpt_pkg::uword_t dividend,
	input  tdpt_pkg::uword_t divisor,
	output logic            done,
	output tdpt_pkg::uword_t quot,
	output tdpt_pkg::uword_t rem
);
	import tdpt_pkg::*;

	logic   busy_q;
	logic   done_q;
	cnt_t   cnt_q;
	uword_t quot_q;
	uword_t rem_q;
	uword_t dvs_q;

	logic [NUM_BITS:0] shifted;
	logic [NUM_BITS:0] diff;
	logic              ge;

	// one quotient bit per cycle
	always_comb begin
		shifted = {rem_q, quot_q[NUM_BITS-1]};
		diff    = shifted - {1'b0, dvs_q};
		ge      = shifted >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= cnt_t'(NUM_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - cnt_t'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			dvs_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[NUM_BITS-2:0], ge};
			rem_q  <= ge ? diff[NUM_BITS-1:0] : shifted[NUM_BITS-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
	assign rem  = rem_q;

endmodule

// ===== rtl/trial_division_prime_test.sv =====
// top level: trial division sequencer around a single serial divider
// short path: negative values, values below 5 and even values finish in the check state;
//   otherwise the divider runs once per odd trial divisor tried, starting from three
// the serial divider (one quotient bit per cycle) sets the pace
// throughput: one transaction at a time; a new one is taken while a result waits
// reset: arst_n clears sequencer and output valid asynchronously
module trial_division_prime_test (
	input  logic        clk,
	input  logic        arst_n,
	tdpt_in_if.sink     query,
	tdpt_out_if.source  verdict
);
	import tdpt_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_CHECK = 2'd1;
	localparam logic [1:0] S_DIV   = 2'd2;
	localparam logic [1:0] S_WAIT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	uword_t     n_q;
	uword_t     d_q;
	logic       res_q;

	logic       out_valid_q;
	num_t       echo_q;
	logic       prime_q;

	logic       div_start;
	uword_t     div_divisor;
	logic       div_done;
	uword_t     div_quot;
	uword_t     div_rem;

	logic       out_free;
	logic       finish;
	logic       finish_val;
	logic       load_out;
	logic       load_val;

	tdpt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (n_q),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	assign out_free    = !out_valid_q || verdict.ready;
	assign div_divisor = (state_q == S_CHECK) ? THREE : uword_t'(d_q + TWO);

	always_comb begin
		state_d    = state_q;
		div_start  = 1'b0;
		finish     = 1'b0;
		finish_val = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (query.valid) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				priority if (n_q[NUM_BITS-1] || n_q < TWO) begin
					finish = 1'b1;
				end else if (n_q == TWO || n_q == THREE) begin
					finish     = 1'b1;
					finish_val = 1'b1;
				end else if (!n_q[0]) begin
					finish = 1'b1;
				end else begin
					div_start = 1'b1;
					state_d   = S_DIV;
				end
			end
			S_DIV: begin
				if (div_done) begin
					// divisor past the square root: no factor found
					priority if (d_q > div_quot) begin
						finish     = 1'b1;
						finish_val = 1'b1;
					end else if (div_rem == '0) begin
						finish = 1'b1;
					end else begin
						div_start = 1'b1;
					end
				end
			end
			S_WAIT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		if (finish) begin
			state_d = out_free ? S_IDLE : S_WAIT;
		end
	end

	assign load_out = (finish && out_free) || (state_q == S_WAIT && out_free);
	assign load_val = (state_q == S_WAIT) ? res_q : finish_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (verdict.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && query.valid) begin
			n_q <= uword_t'(query.number);
		end
		if (div_start) begin
			d_q <= div_divisor;
		end
		if (finish) begin
			res_q <= finish_val;
		end
		if (load_out) begin
			echo_q  <= num_t'(n_q);
			prime_q <= load_val;
		end
	end

	assign query.ready         = (state_q == S_IDLE);
	assign verdict.valid       = out_valid_q;
	assign verdict.number_echo = echo_q;
	assign verdict.is_prime    = prime_q;

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside the divide state");

	a_trial_odd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> d_q[0])
		else $error("even trial divisor");

	a_neg_not_prime: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && echo_q[NUM_BITS-1] |-> !prime_q)
		else $error("negative value reported prime");

	a_even_not_prime: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !echo_q[0] && uword_t'(echo_q) != TWO |-> !prime_q)
		else $error("even value other than two reported prime");

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the trial division prime test
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tdpt_pkg::*;

	localparam int WATCHDOG_LIMIT = 2_500_000;
	localparam int LONG_HOLD      = 3000;
	localparam int HOLD_AFTER     = 40;
	localparam int RANDOM_ITEMS   = 76;

	typedef struct {
		num_t number_echo;
		logic is_prime;
	} verdict_t;

	logic clk;
	logic arst_n;

	tdpt_in_if  query_ch ();
	tdpt_out_if verdict_ch ();

	trial_division_prime_test u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.query   (query_ch),
		.verdict (verdict_ch)
	);

	num_t     numbers_to_send[$];
	verdict_t verdicts_due[$];

	int  n_items;
	int  n_accepted;
	int  n_results;
	int  n_errors;
	int  n_primes;
	int  n_negative;
	int  quiet_cycles;
	int  burst_left;
	int  gap_left;
	int  hold_left;
	int  rx_cycle;
	bit  hold_done;
	bit  query_taken;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// trial division over odd divisors while d*d <= n, bound kept as d <= n/d
	function automatic verdict_t prime_verdict(num_t value);
		verdict_t           v;
		longint unsigned    n;
		longint unsigned    d;
		v.number_echo = value;
		v.is_prime    = 1'b0;
		n = longint'(unsigned'(value));
		if (value < 0 || n < 2) begin
			return v;
		end
		if (n == 2 || n == 3) begin
			v.is_prime = 1'b1;
			return v;
		end
		if (n[0] == 1'b0) begin
			return v;
		end
		for (d = 3; d <= n / d; d += 2) begin
			if (n % d == 0) begin
				return v;
			end
		end
		v.is_prime = 1'b1;
		return v;
	endfunction

	// query driver: bursts of random length separated by random gaps
	always @(negedge clk) begin
		if (!arst_n) begin
			query_ch.valid <= 1'b0;
		end else if (!query_ch.valid || query_taken) begin
			if (gap_left > 0) begin
				gap_left--;
				query_ch.valid <= 1'b0;
			end else if (numbers_to_send.size() > 0) begin
				query_ch.valid  <= 1'b1;
				query_ch.number <= numbers_to_send.pop_front();
				if (burst_left > 0) begin
					burst_left--;
				end
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
				end
			end else begin
				query_ch.valid <= 1'b0;
			end
		end
	end

	// verdict receiver: rotating stall pattern plus one long hold-off
	always @(negedge clk) begin
		if (!arst_n) begin
			verdict_ch.ready <= 1'b0;
		end else begin
			rx_cycle++;
			if (hold_left > 0) begin
				hold_left--;
				verdict_ch.ready <= 1'b0;
			end else if (!hold_done && n_results >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
				verdict_ch.ready <= 1'b0;
			end else begin
				case ((rx_cycle / 101) % 3)
					0: verdict_ch.ready <= 1'b1;
					1: verdict_ch.ready <= $urandom_range(0, 1);
					default: verdict_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// monitor: check the verdict transaction, then record the query transaction
	always @(posedge clk) begin
		verdict_t want;
		query_taken <= arst_n && query_ch.valid && query_ch.ready;
		if (arst_n && verdict_ch.valid && verdict_ch.ready) begin
			n_results++;
			if (verdict_ch.is_prime === 1'b1) begin
				n_primes++;
			end
			if (verdicts_due.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected verdict, echo %0d prime %0b", $realtime,
					verdict_ch.number_echo, verdict_ch.is_prime);
			end else begin
				want = verdicts_due.pop_front();
				if (verdict_ch.number_echo !== want.number_echo) begin
					n_errors++;
					$display("%0t: number_echo expected %0d got %0d", $realtime,
						want.number_echo, verdict_ch.number_echo);
				end
				if (verdict_ch.is_prime !== want.is_prime) begin
					n_errors++;
					$display("%0t: is_prime of %0d expected %0b got %0b", $realtime,
						want.number_echo, want.is_prime, verdict_ch.is_prime);
				end
			end
		end
		if (arst_n && query_ch.valid && query_ch.ready) begin
			n_accepted++;
			if (query_ch.number < 0) begin
				n_negative++;
			end
			verdicts_due.push_back(prime_verdict(query_ch.number));
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((query_ch.valid && query_ch.ready) || (verdict_ch.valid && verdict_ch.ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $realtime, quiet_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		num_t          directed[$];
		int unsigned   r;
		int unsigned   kind;
		arst_n           = 1'b0;
		query_ch.valid   = 1'b0;
		query_ch.number  = '0;
		verdict_ch.ready = 1'b0;

		// edges of the range, tiny values, prime squares, a large prime last
		directed = '{num_t'(0), num_t'(1), num_t'(2), num_t'(3), num_t'(4), num_t'(5),
			num_t'(6), num_t'(7), num_t'(8), num_t'(9), num_t'(15), num_t'(25),
			num_t'(49), num_t'(97), num_t'(121), num_t'(-1), num_t'(-2), num_t'(-3),
			num_t'(32'h8000_0000), num_t'(2147483646), num_t'(2147483645),
			num_t'(65521), num_t'(65537), num_t'(2147483647)};
		foreach (directed[i]) begin
			numbers_to_send.push_back(directed[i]);
		end

		// mostly cheap cases, small values for the slow odd path
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			kind = $urandom_range(0, 19);
			if (kind < 5) begin
				numbers_to_send.push_back(num_t'($urandom | 32'h8000_0000));
			end else if (kind < 9) begin
				numbers_to_send.push_back(num_t'($urandom & 32'h7fff_fffe));
			end else if (kind < 12) begin
				// large odd multiple of three
				r = 3 * $urandom_range(1, 715827881);
				if (r[0] == 1'b0) begin
					r = r - 3;
				end
				numbers_to_send.push_back(num_t'(r));
			end else if (kind < 18) begin
				numbers_to_send.push_back(num_t'($urandom_range(0, 4095)));
			end else begin
				numbers_to_send.push_back(num_t'($urandom_range(4096, 1 << 20)));
			end
		end
		n_items = numbers_to_send.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (n_accepted != n_items) begin
			@(posedge clk);
		end
		while (verdicts_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);

		$display("run covered %0d queries, %0d negative, %0d reported prime", n_items,
			n_negative, n_primes);
		$display("long verdict hold-off applied: %0d, checker errors: %0d", hold_done, n_errors);
		if (n_errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
